// ===== rtl/dtq_pkg.sv =====
// Package for the deadline timer queue: sizes, codes, slot record and cell command.
// No dependencies; every rtl file refers to it by scoped names.
package dtq_pkg;

  localparam int SLOTS     = 16;
  localparam int TIME_BITS = 48;
  localparam int ID_W      = 16;
  localparam int IV_W      = 32;
  localparam int MAX_OUT   = 16;
  localparam int IDX_W     = $clog2(MAX_OUT);
  localparam int CNT_W     = $clog2(MAX_OUT + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_SWEEP  = 2'd2,
    OP_BAD    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_NONE    = 2'd2,
    KIND_RSVD    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_DUP      = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACK,
    S_POP,
    S_REARM,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_e;

  typedef struct packed {
    logic                 valid;
    logic [TIME_BITS-1:0] deadline;
    logic [IV_W-1:0]      interval;
    logic                 rep;
    logic [ID_W-1:0]      id;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
  } cell_cmd_t;

endpackage

// ===== rtl/dtq_cell.sv =====
// One slot of the sorted timer chain: keeps an entry, shifts toward head or tail.
// Depends on dtq_pkg.
module dtq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dtq_pkg::cell_cmd_t cmd_i,
  input  dtq_pkg::entry_t   cand_i,
  input  dtq_pkg::entry_t   prev_i,
  input  dtq_pkg::entry_t   next_i,
  input  logic              prev_lt_i,
  input  logic              hit_i,
  output logic              lt_o,
  output logic              hit_o,
  output dtq_pkg::entry_t   entry_o
);

  dtq_pkg::entry_t ent_q;
  dtq_pkg::entry_t ent_d;
  logic            valid_q;

  assign lt_o  = valid_q &&
                 ({ent_q.deadline, ent_q.id} < {cand_i.deadline, cand_i.id});
  assign hit_o = hit_i | (valid_q && (ent_q.id == cand_i.id));

  always_comb begin
    ent_d       = ent_q;
    ent_d.valid = valid_q;
    unique case (cmd_i.op)
      dtq_pkg::CELL_INSERT: begin
        if (!lt_o) begin
          ent_d = prev_lt_i ? cand_i : prev_i;
        end
      end
      dtq_pkg::CELL_REMOVE: begin
        if (hit_o) begin
          ent_d = next_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ent_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_comb begin
    entry_o       = ent_q;
    entry_o.valid = valid_q;
  end

endmodule

// ===== rtl/deadline_timer_queue_unit.sv =====
// Deadline timer queue: a sorted chain of timer cells with a small sweep controller.
// Depends on dtq_pkg and dtq_cell.
// Add, delete: the cells update when the item is taken; the result is strobed in the next cycle.
// Expire sweep with n due timers: pop steps, then rearm steps, then n results on
// consecutive cycles; a single result when none is due.
// Throughput: one item at a time; busy stays high until its last result is out.
// Reset (asynchronous, active low) empties the queue at once; the receiver cannot stall.
module deadline_timer_queue_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode_i,
  input  logic [dtq_pkg::ID_W-1:0]      timer_id_i,
  input  logic [dtq_pkg::TIME_BITS-1:0] deadline_i,
  input  logic [dtq_pkg::IV_W-1:0]      interval_i,
  input  logic                          repeat_req_i,
  input  logic [dtq_pkg::TIME_BITS-1:0] now_i,
  output logic                          result_valid_o,
  output logic [1:0]                    kind_o,
  output logic [dtq_pkg::ID_W-1:0]      expired_id_o,
  output logic [1:0]                    status_o,
  output logic                          alarm_on_o,
  output logic [dtq_pkg::TIME_BITS-1:0] next_deadline_o,
  output logic                          last_o
);

  localparam int N = dtq_pkg::SLOTS;

  dtq_pkg::state_e    state_q, state_d;
  dtq_pkg::cell_cmd_t cmd;
  dtq_pkg::entry_t    cand;
  dtq_pkg::entry_t    cells   [N];
  logic [N-1:0]       lt;
  logic [N-1:0]       hit;

  // sweep bookkeeping
  logic [dtq_pkg::TIME_BITS-1:0] now_q;
  logic [dtq_pkg::CNT_W-1:0]     n_q, n_d;
  logic [dtq_pkg::CNT_W-1:0]     k_q, k_d;
  logic [dtq_pkg::ID_W-1:0]      gone_id  [dtq_pkg::MAX_OUT];
  logic [dtq_pkg::IV_W-1:0]      gone_iv  [dtq_pkg::MAX_OUT];
  logic                          gone_rep [dtq_pkg::MAX_OUT];
  logic [dtq_pkg::IDX_W-1:0]     k_idx;

  // acknowledge fields
  logic [1:0]               ack_kind_q, ack_kind_d;
  logic [1:0]               ack_status_q, ack_status_d;
  logic [dtq_pkg::ID_W-1:0] ack_id_q, ack_id_d;

  logic                          accept;
  logic                          found;
  logic                          full;
  logic                          head_due;
  logic                          pop_go;
  logic                          pop_now;
  logic [dtq_pkg::TIME_BITS:0]   rearm_sum;
  logic [dtq_pkg::TIME_BITS-1:0] rearm_dl;
  logic                          k_last;

  assign accept   = start && !busy;
  assign busy     = (state_q != dtq_pkg::S_IDLE);
  assign found    = hit[N-1];
  assign full     = cells[N-1].valid;
  assign k_idx    = k_q[dtq_pkg::IDX_W-1:0];
  assign k_last   = (k_q == n_q - dtq_pkg::CNT_W'(1));
  assign head_due = cells[0].valid && (cells[0].deadline <= now_q);
  assign pop_go   = head_due && (n_q < dtq_pkg::CNT_W'(dtq_pkg::MAX_OUT));
  // pop the head: every cell takes its tail neighbor
  assign pop_now  = (state_q == dtq_pkg::S_POP) && pop_go;

  // rearm deadline: now + interval, pinned at the top of the time range
  assign rearm_sum = {1'b0, now_q} + {{(dtq_pkg::TIME_BITS + 1 - dtq_pkg::IV_W){1'b0}},
                                      gone_iv[k_idx]};
  assign rearm_dl  = rearm_sum[dtq_pkg::TIME_BITS] ? '1 :
                     rearm_sum[dtq_pkg::TIME_BITS-1:0];

  // candidate entry seen by every cell: a rearm in the rearm state, the port item otherwise
  always_comb begin
    if (state_q == dtq_pkg::S_REARM) begin
      cand.valid    = 1'b1;
      cand.deadline = rearm_dl;
      cand.interval = gone_iv[k_idx];
      cand.rep      = gone_rep[k_idx];
      cand.id       = gone_id[k_idx];
    end else begin
      cand.valid    = 1'b1;
      cand.deadline = deadline_i;
      cand.interval = interval_i;
      cand.rep      = repeat_req_i;
      cand.id       = timer_id_i;
    end
  end

  // the cell chain: head at index 0, kept in (deadline, id) order
  for (genvar i = 0; i < N; i++) begin : g_cell
    dtq_pkg::entry_t prev_ent;
    dtq_pkg::entry_t next_ent;
    logic            prev_lt;
    logic            hit_in;
    if (i == 0) begin : g_head
      assign prev_ent = '0;
      assign prev_lt  = 1'b1;
      assign hit_in   = pop_now;
    end else begin : g_body
      assign prev_ent = cells[i-1];
      assign prev_lt  = lt[i-1];
      assign hit_in   = hit[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = cells[i+1];
    end
    dtq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .cand_i    (cand),
      .prev_i    (prev_ent),
      .next_i    (next_ent),
      .prev_lt_i (prev_lt),
      .hit_i     (hit_in),
      .lt_o      (lt[i]),
      .hit_o     (hit[i]),
      .entry_o   (cells[i])
    );
  end

  // controller: next state, cell command, acknowledge fields
  always_comb begin
    state_d      = state_q;
    cmd.op       = dtq_pkg::CELL_HOLD;
    n_d          = n_q;
    k_d          = k_q;
    ack_kind_d   = ack_kind_q;
    ack_status_d = ack_status_q;
    ack_id_d     = ack_id_q;
    unique case (state_q)
      dtq_pkg::S_IDLE: begin
        if (accept) begin
          ack_kind_d   = dtq_pkg::KIND_ACK;
          ack_id_d     = timer_id_i;
          ack_status_d = dtq_pkg::ST_OK;
          state_d      = dtq_pkg::S_ACK;
          unique case (dtq_pkg::opcode_e'(opcode_i))
            dtq_pkg::OP_ADD: begin
              priority if (found) begin
                ack_status_d = dtq_pkg::ST_DUP;
              end else if (full) begin
                ack_status_d = dtq_pkg::ST_FULL;
              end else begin
                cmd.op = dtq_pkg::CELL_INSERT;
              end
            end
            dtq_pkg::OP_DELETE: begin
              cmd.op       = dtq_pkg::CELL_REMOVE;
              ack_status_d = found ? dtq_pkg::ST_OK : dtq_pkg::ST_NOTFOUND;
            end
            dtq_pkg::OP_SWEEP: begin
              n_d     = '0;
              state_d = dtq_pkg::S_POP;
            end
            default: begin
              ack_status_d = dtq_pkg::ST_NOTFOUND;
            end
          endcase
        end
      end
      dtq_pkg::S_ACK: begin
        state_d = dtq_pkg::S_IDLE;
      end
      dtq_pkg::S_POP: begin
        if (pop_go) begin
          cmd.op  = dtq_pkg::CELL_REMOVE;
          n_d     = n_q + dtq_pkg::CNT_W'(1);
        end else if (n_q == '0) begin
          ack_kind_d   = dtq_pkg::KIND_NONE;
          ack_id_d     = '0;
          ack_status_d = dtq_pkg::ST_OK;
          state_d      = dtq_pkg::S_ACK;
        end else begin
          k_d     = '0;
          state_d = dtq_pkg::S_REARM;
        end
      end
      dtq_pkg::S_REARM: begin
        if (gone_rep[k_idx] && (gone_iv[k_idx] != '0)) begin
          cmd.op = dtq_pkg::CELL_INSERT;
        end
        if (k_last) begin
          k_d     = '0;
          state_d = dtq_pkg::S_EMIT;
        end else begin
          k_d = k_q + dtq_pkg::CNT_W'(1);
        end
      end
      dtq_pkg::S_EMIT: begin
        if (k_last) begin
          state_d = dtq_pkg::S_IDLE;
        end else begin
          k_d = k_q + dtq_pkg::CNT_W'(1);
        end
      end
      default: begin
        state_d = dtq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtq_pkg::S_IDLE;
      n_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      k_q     <= k_d;
    end
  end

  // payload registers: hold the sweep time, acknowledge fields and popped timers
  always_ff @(posedge clk_i) begin
    ack_kind_q   <= ack_kind_d;
    ack_status_q <= ack_status_d;
    ack_id_q     <= ack_id_d;
    if (accept) begin
      now_q <= now_i;
    end
    if (pop_now) begin
      gone_id[n_q[dtq_pkg::IDX_W-1:0]]  <= cells[0].id;
      gone_iv[n_q[dtq_pkg::IDX_W-1:0]]  <= cells[0].interval;
      gone_rep[n_q[dtq_pkg::IDX_W-1:0]] <= cells[0].rep;
    end
  end

  // result transfer: head of the chain gives the alarm state
  always_comb begin
    result_valid_o  = (state_q == dtq_pkg::S_ACK) || (state_q == dtq_pkg::S_EMIT);
    alarm_on_o      = cells[0].valid;
    next_deadline_o = cells[0].valid ? cells[0].deadline : '0;
    if (state_q == dtq_pkg::S_EMIT) begin
      kind_o       = dtq_pkg::KIND_EXPIRED;
      expired_id_o = gone_id[k_idx];
      status_o     = dtq_pkg::ST_OK;
      last_o       = k_last;
    end else begin
      kind_o       = ack_kind_q;
      expired_id_o = ack_id_q;
      status_o     = ack_status_q;
      last_o       = 1'b1;
    end
  end

endmodule

// ===== rtl/dtq_checker.sv =====
// Port-level checks for the deadline timer queue, bound to the top level.
// Depends on dtq_pkg and deadline_timer_queue_unit.
module dtq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          result_valid_o,
  input logic                          alarm_on_o,
  input logic [dtq_pkg::TIME_BITS-1:0] next_deadline_o,
  input logic                          last_o
);

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result transfer while not busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_no_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !alarm_on_o) |-> (next_deadline_o == '0))
    else $error("deadline reported with alarm off");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |=> result_valid_o) else $error("gap in result burst");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !busy) else $error("busy after last result");

endmodule

bind deadline_timer_queue_unit dtq_checker u_dtq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_valid_o  (result_valid_o),
  .alarm_on_o      (alarm_on_o),
  .next_deadline_o (next_deadline_o),
  .last_o          (last_o)
);

// ===== tb/sv/deadline_timer_queue_unit_test.sv =====
`timescale 1ns / 100ps
// Testbench for deadline_timer_queue_unit: directed and random add, delete and sweep
// transfers checked against an in-bench timer table. Depends on dtq_pkg and the RTL.
module deadline_timer_queue_unit_test;

  typedef struct packed {
    logic [1:0]                    kind;
    logic [dtq_pkg::ID_W-1:0]      id;
    logic [1:0]                    status;
    logic                          alarm;
    logic [dtq_pkg::TIME_BITS-1:0] next_dl;
    logic                          last;
  } timer_result_t;

  localparam logic [dtq_pkg::TIME_BITS-1:0] TIME_MAX = '1;

  // Timer table and queue of results it predicts.
  class timer_scoreboard;
    bit                            used[dtq_pkg::SLOTS];
    logic [dtq_pkg::TIME_BITS-1:0] dl[dtq_pkg::SLOTS];
    logic [dtq_pkg::IV_W-1:0]      iv[dtq_pkg::SLOTS];
    bit                            rep[dtq_pkg::SLOTS];
    logic [dtq_pkg::ID_W-1:0]      tid[dtq_pkg::SLOTS];
    timer_result_t                 pending[$];
    int                            mismatches;

    function int head_slot();
      int best;
      best = -1;
      for (int i = 0; i < dtq_pkg::SLOTS; i++)
        if (used[i] && (best < 0 || dl[i] < dl[best] ||
            (dl[i] == dl[best] && tid[i] < tid[best]))) best = i;
      return best;
    endfunction

    function int find_id(logic [dtq_pkg::ID_W-1:0] id);
      for (int i = 0; i < dtq_pkg::SLOTS; i++) if (used[i] && tid[i] == id) return i;
      return -1;
    endfunction

    function int count();
      int n;
      n = 0;
      foreach (used[i]) n += used[i];
      return n;
    endfunction

    function void push(dtq_pkg::kind_e k, logic [dtq_pkg::ID_W-1:0] id,
                       dtq_pkg::status_e st, bit lst);
      timer_result_t r;
      int h;
      h = head_slot();
      r.kind = k; r.id = id; r.status = st; r.last = lst;
      r.alarm = (h >= 0);
      r.next_dl = (h >= 0) ? dl[h] : '0;
      pending = {pending, r};
    endfunction

    // Note an accepted command and predict every result it causes.
    function void note_command(dtq_pkg::opcode_e op, logic [dtq_pkg::ID_W-1:0] id,
                               logic [dtq_pkg::TIME_BITS-1:0] d,
                               logic [dtq_pkg::IV_W-1:0] v, bit r,
                               logic [dtq_pkg::TIME_BITS-1:0] now);
      int s, n, h;
      int gone[dtq_pkg::MAX_OUT];
      dtq_pkg::status_e st;
      case (op)
        dtq_pkg::OP_ADD: begin
          st = dtq_pkg::ST_OK;
          if (find_id(id) >= 0) st = dtq_pkg::ST_DUP;
          else begin
            s = -1;
            for (int i = dtq_pkg::SLOTS - 1; i >= 0; i--) if (!used[i]) s = i;
            if (s < 0) st = dtq_pkg::ST_FULL;
            else begin
              used[s] = 1; dl[s] = d; iv[s] = v; rep[s] = r; tid[s] = id;
            end
          end
          push(dtq_pkg::KIND_ACK, id, st, 1'b1);
        end
        dtq_pkg::OP_DELETE: begin
          s = find_id(id);
          if (s >= 0) used[s] = 0;
          push(dtq_pkg::KIND_ACK, id, (s >= 0) ? dtq_pkg::ST_OK : dtq_pkg::ST_NOTFOUND,
               1'b1);
        end
        dtq_pkg::OP_SWEEP: begin
          n = 0;
          while (n < dtq_pkg::MAX_OUT) begin
            h = head_slot();
            if (h < 0 || dl[h] > now) break;
            used[h] = 0;
            gone[n++] = h;
          end
          if (n == 0) push(dtq_pkg::KIND_NONE, '0, dtq_pkg::ST_OK, 1'b1);
          else begin
            // Rearm first: every result carries the alarm as it stands after the sweep.
            for (int k = 0; k < n; k++)
              if (rep[gone[k]] && iv[gone[k]] != 0) begin
                dl[gone[k]] = ({16'd0, iv[gone[k]]} > TIME_MAX - now) ? TIME_MAX
                              : now + iv[gone[k]];
                used[gone[k]] = 1;
              end
            for (int k = 0; k < n; k++)
              push(dtq_pkg::KIND_EXPIRED, tid[gone[k]], dtq_pkg::ST_OK, k == n - 1);
          end
        end
        default: push(dtq_pkg::KIND_ACK, id, dtq_pkg::ST_NOTFOUND, 1'b1);
      endcase
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic                          clk_i = 0;
  logic                          rst_ni = 0;
  logic                          start = 0;
  logic                          busy;
  logic [1:0]                    opcode_i = '0;
  logic [dtq_pkg::ID_W-1:0]      timer_id_i = '0;
  logic [dtq_pkg::TIME_BITS-1:0] deadline_i = '0;
  logic [dtq_pkg::IV_W-1:0]      interval_i = '0;
  logic                          repeat_req_i = 0;
  logic [dtq_pkg::TIME_BITS-1:0] now_i = '0;
  logic                          result_valid_o;
  logic [1:0]                    kind_o;
  logic [dtq_pkg::ID_W-1:0]      expired_id_o;
  logic [1:0]                    status_o;
  logic                          alarm_on_o;
  logic [dtq_pkg::TIME_BITS-1:0] next_deadline_o;
  logic                          last_o;

  deadline_timer_queue_unit dut (.*);

  timer_scoreboard board = new();
  int idle_pct;
  logic [dtq_pkg::TIME_BITS-1:0] clock_ms;  // running "current time" for well-formed traffic

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Sample each result strobe at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      board.check_result({kind_o, expired_id_o, status_o, alarm_on_o, next_deadline_o,
                          last_o});
  end

  // Drive one command and hold it until the block takes the transfer.
  task automatic send(dtq_pkg::opcode_e op, logic [dtq_pkg::ID_W-1:0] id,
                      logic [dtq_pkg::TIME_BITS-1:0] d, logic [dtq_pkg::IV_W-1:0] v,
                      bit r, logic [dtq_pkg::TIME_BITS-1:0] now);
    do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    start <= 1'b1; opcode_i <= op; timer_id_i <= id; deadline_i <= d;
    interval_i <= v; repeat_req_i <= r; now_i <= now;
    do @(posedge clk_i); while (busy);
    board.note_command(op, id, d, v, r, now);
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  // Pick an id: mostly small pool so deletes and duplicates hit, sometimes anything.
  function automatic logic [dtq_pkg::ID_W-1:0] pick_id();
    return ($urandom_range(9) == 0) ? dtq_pkg::ID_W'($urandom)
                                    : dtq_pkg::ID_W'($urandom_range(23));
  endfunction

  function automatic logic [dtq_pkg::TIME_BITS-1:0] rand_time();
    return dtq_pkg::TIME_BITS'({$urandom, $urandom});
  endfunction

  task automatic random_item();
    int sel;
    logic [dtq_pkg::TIME_BITS-1:0] d;
    sel = $urandom_range(99);
    d = clock_ms + $urandom_range(400);
    if ($urandom_range(19) == 0) d = rand_time();
    if (sel < 45)
      send(dtq_pkg::OP_ADD, pick_id(), d,
           ($urandom_range(3) == 0) ? $urandom : $urandom_range(300),
           1'($urandom_range(1)), '0);
    else if (sel < 65)
      send(dtq_pkg::OP_DELETE, pick_id(), '0, '0, 1'b0, '0);
    else if (sel < 97) begin
      clock_ms += $urandom_range(250);
      send(dtq_pkg::OP_SWEEP, '0, '0, '0, 1'b0,
           ($urandom_range(29) == 0) ? rand_time() : clock_ms);
    end else
      send(dtq_pkg::OP_BAD, pick_id(), rand_time(), $urandom, 1'b1, rand_time());
  endtask

  initial begin
    idle_pct = 0;
    clock_ms = 1000;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: empty sweep, delete of unknown id, bad opcode, field extremes.
    send(dtq_pkg::OP_SWEEP, '0, '0, '0, 1'b0, '0);
    send(dtq_pkg::OP_DELETE, '1, '0, '0, 1'b0, '0);
    send(dtq_pkg::OP_BAD, 16'h1234, '1, '1, 1'b1, '1);
    send(dtq_pkg::OP_ADD, '1, '1, '1, 1'b1, '0);
    send(dtq_pkg::OP_ADD, '1, 48'd5, 32'd5, 1'b0, '0);           // duplicate id
    send(dtq_pkg::OP_ADD, 16'd0, 48'd100, 32'd50, 1'b1, '0);
    send(dtq_pkg::OP_ADD, 16'd1, 48'd100, 32'd0, 1'b1, '0);      // tie, repeat w/o interval
    send(dtq_pkg::OP_ADD, 16'd2, 48'd90, '1, 1'b1, '0);
    for (int i = 3; i < dtq_pkg::SLOTS; i++)
      send(dtq_pkg::OP_ADD, dtq_pkg::ID_W'(i), 48'd200, 32'd7, 1'b0, '0);
    send(dtq_pkg::OP_ADD, 16'd99, 48'd1, 32'd1, 1'b0, '0);       // table full
    send(dtq_pkg::OP_SWEEP, '0, '0, '0, 1'b0, 48'd89);           // nothing due
    send(dtq_pkg::OP_SWEEP, '0, '0, '0, 1'b0, TIME_MAX - 3);     // 15 due, rearm saturates
    send(dtq_pkg::OP_SWEEP, '0, '0, '0, 1'b0, '1);               // all three left are due
    send(dtq_pkg::OP_DELETE, '1, '0, '0, 1'b0, '0);
    send(dtq_pkg::OP_DELETE, 16'd0, '0, '0, 1'b0, '0);
    while (board.count() > 0)
      send(dtq_pkg::OP_DELETE, board.tid[board.head_slot()], '0, '0, 1'b0, '0);

    // Random phases with varying idle on the sending side.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 68 : (ph == 3) ? 9 : 0;
      repeat (100) random_item();
    end

    while (board.pending.size() > 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
